[hw/rtl/tpc_pkg.sv]
// shared constants, codes and control structs of the timestamp preload cache
`timescale 1ns / 1ps

package tpc_pkg;

   // default sizes
   localparam int TPC_CAPACITY = 16;
   localparam int TPC_KEY_BITS = 16;

   // fixed field widths
   localparam int MODE_W     = 2;
   localparam int CELL_KEY_W = 16;
   localparam int TICK_W     = 32;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // request modes
   localparam logic [MODE_W-1:0] MODE_PRELOAD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NOTICE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SWEEP   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

   // final status codes
   localparam logic [STATUS_W-1:0] ST_REFRESHED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ADDED       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REFUSED_FUL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REFUSED_UNL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REMOVED     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_SWEPT       = 3'd6;
   localparam logic [STATUS_W-1:0] ST_CLEARED     = 3'd7;

   // result word kinds
   localparam logic KIND_NOTE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ENTRIES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_ENTRIES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EXPIRY_DELAY  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EVICT_MIN_AGE = 2'd3;

   // register reset values
   localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST   = 5'd16;
   localparam logic [COUNT_W-1:0] MIN_ENTRIES_RST   = 5'd0;
   localparam logic [TICK_W-1:0]  EXPIRY_DELAY_RST  = 32'd0;
   localparam logic [TICK_W-1:0]  EVICT_MIN_AGE_RST = 32'd1000;

   // what one pass over the table looks for
   typedef enum logic [1:0] {
      SCAN_FIND,
      SCAN_OLDEST,
      SCAN_NEXT
   } scan_kind_type;

   // table storage control
   typedef struct packed {
      logic rd_en;
      logic key_wr;
      logic time_wr;
      logic set_vld;
      logic clr_vld;
   } store_ctrl_type;

   // table read word status
   typedef struct packed {
      logic ok;
      logic vld;
   } store_rd_type;

   // scan unit control
   typedef struct packed {
      logic          start;
      scan_kind_type kind;
      logic          freed;
   } scan_ctrl_type;

   // scan unit result flags
   typedef struct packed {
      logic best_ok;
      logic free_ok;
   } scan_flag_type;

endpackage

[hw/rtl/tpc_if.sv]
// valid/ready channels of the timestamp preload cache
`timescale 1ns / 1ps

// request channel
interface tpc_req_if;
   import tpc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [CELL_KEY_W-1:0] cell_key;
   logic [TICK_W-1:0]     now_ticks;
   logic                  cell_unloaded;

   modport source (output valid, mode, cell_key, now_ticks, cell_unloaded, input ready);
   modport sink   (input valid, mode, cell_key, now_ticks, cell_unloaded, output ready);
endinterface

// result channel
interface tpc_rsp_if;
   import tpc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [CELL_KEY_W-1:0] removed_key;
   logic [STATUS_W-1:0]   status;
   logic [COUNT_W-1:0]    entry_count;
   logic                  last;

   modport source (output valid, kind, removed_key, status, entry_count, last, input ready);
   modport sink   (input valid, kind, removed_key, status, entry_count, last, output ready);
endinterface

// register write channel
interface tpc_csr_if;
   import tpc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/tpc_csr.sv]
// configuration registers of the timestamp preload cache
`timescale 1ns / 1ps

module tpc_csr (
   input  logic                          clock,
   input  logic                          reset,
   tpc_csr_if.sink                       csr,
   output logic [tpc_pkg::COUNT_W-1:0]   max_entries,
   output logic [tpc_pkg::COUNT_W-1:0]   min_entries,
   output logic [tpc_pkg::TICK_W-1:0]    expiry_delay,
   output logic [tpc_pkg::TICK_W-1:0]    evict_min_age
);
   import tpc_pkg::*;

   logic [COUNT_W-1:0] max_entries_ff;
   logic [COUNT_W-1:0] min_entries_ff;
   logic [TICK_W-1:0]  expiry_delay_ff;
   logic [TICK_W-1:0]  evict_min_age_ff;

   assign csr.ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff   <= MAX_ENTRIES_RST;
         min_entries_ff   <= MIN_ENTRIES_RST;
         expiry_delay_ff  <= EXPIRY_DELAY_RST;
         evict_min_age_ff <= EVICT_MIN_AGE_RST;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_MAX_ENTRIES:   max_entries_ff   <= csr.data[COUNT_W-1:0];
            REG_MIN_ENTRIES:   min_entries_ff   <= csr.data[COUNT_W-1:0];
            REG_EXPIRY_DELAY:  expiry_delay_ff  <= csr.data[TICK_W-1:0];
            REG_EVICT_MIN_AGE: evict_min_age_ff <= csr.data[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   assign max_entries   = max_entries_ff;
   assign min_entries   = min_entries_ff;
   assign expiry_delay  = expiry_delay_ff;
   assign evict_min_age = evict_min_age_ff;

endmodule

[hw/rtl/tpc_store.sv]
// entry table: key and time memories with registered read, valid bits in flops
`timescale 1ns / 1ps

module tpc_store #(
   parameter int CAPACITY = tpc_pkg::TPC_CAPACITY,
   parameter int KEY_BITS = tpc_pkg::TPC_KEY_BITS,
   parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tpc_pkg::store_ctrl_type     ctrl,
   input  logic [AW-1:0]               rd_addr,
   input  logic [AW-1:0]               wr_addr,
   input  logic [KEY_BITS-1:0]         wr_key,
   input  logic [tpc_pkg::TICK_W-1:0]  wr_time,
   output tpc_pkg::store_rd_type       rd_stat,
   output logic [AW-1:0]               rd_slot,
   output logic [KEY_BITS-1:0]         rd_key,
   output logic [tpc_pkg::TICK_W-1:0]  rd_time
);
   import tpc_pkg::*;

   logic [KEY_BITS-1:0] key_mem_ff  [CAPACITY];
   logic [TICK_W-1:0]   time_mem_ff [CAPACITY];
   logic [CAPACITY-1:0] valid_ff;
   logic                rd_ok_ff;
   logic                rd_vld_ff;
   logic [AW-1:0]       rd_slot_ff;
   logic [KEY_BITS-1:0] rd_key_ff;
   logic [TICK_W-1:0]   rd_time_ff;

   // memory writes
   always_ff @(posedge clock) begin
      if (ctrl.key_wr) begin
         key_mem_ff[wr_addr] <= wr_key;
      end
      if (ctrl.time_wr) begin
         time_mem_ff[wr_addr] <= wr_time;
      end
   end

   // memory read port
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_key_ff  <= key_mem_ff[rd_addr];
         rd_time_ff <= time_mem_ff[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
         rd_slot_ff <= rd_addr;
      end
   end

   // valid bits and read strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         rd_ok_ff <= ctrl.rd_en;
         if (ctrl.set_vld) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (ctrl.clr_vld) begin
            valid_ff[wr_addr] <= 1'b0;
         end
      end
   end

   assign rd_stat.ok  = rd_ok_ff;
   assign rd_stat.vld = rd_vld_ff;
   assign rd_slot     = rd_slot_ff;
   assign rd_key      = rd_key_ff;
   assign rd_time     = rd_time_ff;

endmodule

[hw/rtl/tpc_scan.sv]
// shared compare unit: match, oldest, next key in order and first free slot
`timescale 1ns / 1ps

module tpc_scan #(
   parameter int CAPACITY = tpc_pkg::TPC_CAPACITY,
   parameter int KEY_BITS = tpc_pkg::TPC_KEY_BITS,
   parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tpc_pkg::scan_ctrl_type      ctrl,
   input  logic [AW-1:0]               freed_slot,
   input  tpc_pkg::store_rd_type       rd_stat,
   input  logic [AW-1:0]               rd_slot,
   input  logic [KEY_BITS-1:0]         rd_key,
   input  logic [tpc_pkg::TICK_W-1:0]  rd_time,
   input  logic [KEY_BITS-1:0]         match_key,
   input  logic [KEY_BITS-1:0]         prev_key,
   input  logic                        has_prev,
   output tpc_pkg::scan_flag_type      flags,
   output logic [AW-1:0]               best_slot,
   output logic [KEY_BITS-1:0]         best_key,
   output logic [tpc_pkg::TICK_W-1:0]  best_time,
   output logic [AW-1:0]               free_slot
);
   import tpc_pkg::*;

   scan_kind_type       kind_ff;
   logic                best_ok_ff;
   logic                free_ok_ff;
   logic [AW-1:0]       best_slot_ff;
   logic [KEY_BITS-1:0] best_key_ff;
   logic [TICK_W-1:0]   best_time_ff;
   logic [AW-1:0]       free_slot_ff;
   logic                take;
   logic                take_free;

   // compare of the word just read against the running best
   always_comb begin
      take      = 1'b0;
      take_free = 1'b0;
      if (rd_stat.ok) begin
         unique case (kind_ff)
            SCAN_FIND: begin
               take      = rd_stat.vld && !best_ok_ff && (rd_key == match_key);
               take_free = !rd_stat.vld && !free_ok_ff;
            end
            SCAN_OLDEST: begin
               take = rd_stat.vld &&
                      (!best_ok_ff || (rd_time < best_time_ff) ||
                       ((rd_time == best_time_ff) && (rd_key < best_key_ff)));
            end
            SCAN_NEXT: begin
               take = rd_stat.vld && (!has_prev || (rd_key > prev_key)) &&
                      (!best_ok_ff || (rd_key < best_key_ff));
            end
            default: ;
         endcase
      end
   end

   // running best and free slot, control part
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= SCAN_FIND;
         best_ok_ff <= 1'b0;
         free_ok_ff <= 1'b0;
      end else if (ctrl.start) begin
         kind_ff    <= ctrl.kind;
         best_ok_ff <= 1'b0;
         if (ctrl.kind == SCAN_FIND) begin
            free_ok_ff <= 1'b0;
         end
      end else begin
         if (take) begin
            best_ok_ff <= 1'b1;
         end
         if (take_free || ctrl.freed) begin
            free_ok_ff <= 1'b1;
         end
      end
   end

   // running best and free slot, payload part
   always_ff @(posedge clock) begin
      if (take) begin
         best_slot_ff <= rd_slot;
         best_key_ff  <= rd_key;
         best_time_ff <= rd_time;
      end
      if (take_free) begin
         free_slot_ff <= rd_slot;
      end else if (ctrl.freed && (!free_ok_ff || (freed_slot < free_slot_ff))) begin
         free_slot_ff <= freed_slot;
      end
   end

   assign flags.best_ok = best_ok_ff;
   assign flags.free_ok = free_ok_ff;
   assign best_slot     = best_slot_ff;
   assign best_key      = best_key_ff;
   assign best_time     = best_time_ff;
   assign free_slot     = free_slot_ff;

endmodule

[hw/rtl/timestamp_preload_cache_policy_core.sv]
// top level: request sequencer, result register and table of the preload cache
`timescale 1ns / 1ps

// Cache of preloaded cells with eviction of the entry of oldest last-use time.
// req: one request word (preload, loaded notice, expire sweep, clear all).
// rsp: zero or more notice words, one per removed key, then one status word
//      with last set. entry_count in each word is the count after that word.
// csr: register writes (max_entries, min_entries, expiry_delay, evict_min_age),
//      always ready; write only while no request is in flight.
// Each table pass reads one slot a cycle from the key/time memory port and
// covers all CAPACITY slots. An unloaded preload is refused with no pass; a
// preload or notice makes one find pass, and each eviction or too-young check
// one more oldest-entry pass. Sweep or clear makes one next-key pass per entry
// in the table plus a last one that finds no further key.
// req.ready is high only between requests. The result register lets the
// next request be taken while the final word still waits; a stalled rsp
// holds the sequencer on the word it is about to send.
// Reset clears the valid bits, the entry count and the registers at once;
// no clearing pass is needed.
module timestamp_preload_cache_policy_core #(
   parameter int CAPACITY = tpc_pkg::TPC_CAPACITY,
   parameter int KEY_BITS = tpc_pkg::TPC_KEY_BITS
) (
   input  logic     clock,
   input  logic     reset,
   tpc_req_if.sink  req,
   tpc_rsp_if.source rsp,
   tpc_csr_if.sink  csr
);
   import tpc_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_FOUND = 4'd2;
   localparam logic [3:0] S_EVCHK = 4'd3;
   localparam logic [3:0] S_EVICT = 4'd4;
   localparam logic [3:0] S_ADD   = 4'd5;
   localparam logic [3:0] S_SWEEP = 4'd6;
   localparam logic [3:0] S_NEXT  = 4'd7;
   localparam logic [3:0] S_NOTE  = 4'd8;
   localparam logic [3:0] S_FINAL = 4'd9;

   logic [COUNT_W-1:0]  max_entries;
   logic [COUNT_W-1:0]  min_entries;
   logic [TICK_W-1:0]   expiry_delay;
   logic [TICK_W-1:0]   evict_min_age;

   store_ctrl_type      st_ctrl;
   store_rd_type        rd_stat;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       rd_slot;
   logic [KEY_BITS-1:0] rd_key;
   logic [TICK_W-1:0]   rd_time;

   scan_ctrl_type       sc_ctrl;
   scan_flag_type       sc_flags;
   logic [AW-1:0]       best_slot;
   logic [KEY_BITS-1:0] best_key;
   logic [TICK_W-1:0]   best_time;
   logic [AW-1:0]       free_slot;

   logic [3:0]          state_ff, state_in;
   logic [3:0]          post_ff, post_in;
   logic [3:0]          ret_ff, ret_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TICK_W-1:0]   now_ff, now_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [KEY_BITS-1:0] note_key_ff, note_key_in;
   logic [KEY_BITS-1:0] prev_ff, prev_in;
   logic                has_prev_ff, has_prev_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [CELL_KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_load;
   logic                  out_free;

   logic [MW-1:0]       count_w;
   logic [MW-1:0]       limit_w;
   logic                at_limit;
   logic                above_min;
   logic [TICK_W-1:0]   age_sel;
   logic [TICK_W:0]     age_sum;
   logic                aged;

   tpc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr),
      .max_entries   (max_entries),
      .min_entries   (min_entries),
      .expiry_delay  (expiry_delay),
      .evict_min_age (evict_min_age)
   );

   tpc_store #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS),
      .AW       (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (st_ctrl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_key  (key_ff),
      .wr_time (now_ff),
      .rd_stat (rd_stat),
      .rd_slot (rd_slot),
      .rd_key  (rd_key),
      .rd_time (rd_time)
   );

   tpc_scan #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS),
      .AW       (AW)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (sc_ctrl),
      .freed_slot (wr_addr),
      .rd_stat    (rd_stat),
      .rd_slot    (rd_slot),
      .rd_key     (rd_key),
      .rd_time    (rd_time),
      .match_key  (key_ff),
      .prev_key   (prev_ff),
      .has_prev   (has_prev_ff),
      .flags      (sc_flags),
      .best_slot  (best_slot),
      .best_key   (best_key),
      .best_time  (best_time),
      .free_slot  (free_slot)
   );

   // count against the add limit and the sweep minimum
   assign count_w   = MW'(count_ff);
   assign limit_w   = (MW'(max_entries) < MW'(CAPACITY)) ? MW'(max_entries) : MW'(CAPACITY);
   assign at_limit  = count_w >= limit_w;
   assign above_min = count_w >= MW'(min_entries);

   // shared age adder: time plus delay against now, one bit wider
   assign age_sel = (state_ff == S_SWEEP) ? expiry_delay : evict_min_age;
   assign age_sum = {1'b0, best_time} + {1'b0, age_sel};
   assign aged    = age_sum < {1'b0, now_ff};

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign rd_addr  = cnt_ff[AW-1:0];
   assign wr_addr  = (state_ff == S_ADD) ? free_slot : best_slot;
   assign req.ready = (state_ff == S_IDLE);

   // request sequencer
   always_comb begin
      state_in    = state_ff;
      post_in     = post_ff;
      ret_in      = ret_ff;
      cnt_in      = cnt_ff;
      count_in    = count_ff;
      mode_in     = mode_ff;
      key_in      = key_ff;
      now_in      = now_ff;
      status_in   = status_ff;
      note_key_in = note_key_ff;
      prev_in     = prev_ff;
      has_prev_in = has_prev_ff;
      st_ctrl     = '0;
      sc_ctrl     = '{start: 1'b0, kind: SCAN_FIND, freed: 1'b0};
      rsp_load      = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               mode_in = req.mode;
               key_in  = KEY_BITS'(req.cell_key);
               now_in  = req.now_ticks;
               cnt_in  = '0;
               if ((req.mode == MODE_PRELOAD) && req.cell_unloaded) begin
                  status_in = ST_REFUSED_UNL;
                  state_in  = S_FINAL;
               end else if ((req.mode == MODE_PRELOAD) || (req.mode == MODE_NOTICE)) begin
                  sc_ctrl.start = 1'b1;
                  sc_ctrl.kind  = SCAN_FIND;
                  post_in       = S_FOUND;
                  state_in      = S_SCAN;
               end else begin
                  has_prev_in   = 1'b0;
                  sc_ctrl.start = 1'b1;
                  sc_ctrl.kind  = SCAN_NEXT;
                  post_in       = S_SWEEP;
                  state_in      = S_SCAN;
               end
            end
         end

         // one slot read per cycle; the last word is compared at the exit edge
         S_SCAN: begin
            if (cnt_ff == CW'(CAPACITY)) begin
               state_in = post_ff;
            end else begin
               st_ctrl.rd_en = 1'b1;
               cnt_in        = cnt_ff + 1'b1;
            end
         end

         S_FOUND: begin
            if (mode_ff == MODE_PRELOAD) begin
               if (sc_flags.best_ok) begin
                  st_ctrl.time_wr = 1'b1;
                  status_in       = ST_REFRESHED;
                  state_in        = S_FINAL;
               end else begin
                  state_in = S_EVCHK;
               end
            end else if (sc_flags.best_ok) begin
               st_ctrl.clr_vld = 1'b1;
               sc_ctrl.freed   = 1'b1;
               count_in        = count_ff - 1'b1;
               note_key_in     = best_key;
               status_in       = ST_REMOVED;
               ret_in          = S_FINAL;
               state_in        = S_NOTE;
            end else begin
               status_in = ST_NOT_FOUND;
               state_in  = S_FINAL;
            end
         end

         S_EVCHK: begin
            if (at_limit) begin
               cnt_in        = '0;
               sc_ctrl.start = 1'b1;
               sc_ctrl.kind  = SCAN_OLDEST;
               post_in       = S_EVICT;
               state_in      = S_SCAN;
            end else begin
               state_in = S_ADD;
            end
         end

         S_EVICT: begin
            if (!sc_flags.best_ok || !aged) begin
               status_in = ST_REFUSED_FUL;
               state_in  = S_FINAL;
            end else begin
               st_ctrl.clr_vld = 1'b1;
               sc_ctrl.freed   = 1'b1;
               count_in        = count_ff - 1'b1;
               note_key_in     = best_key;
               ret_in          = S_EVCHK;
               state_in        = S_NOTE;
            end
         end

         S_ADD: begin
            if (sc_flags.free_ok) begin
               st_ctrl.key_wr  = 1'b1;
               st_ctrl.time_wr = 1'b1;
               st_ctrl.set_vld = 1'b1;
               count_in        = count_ff + 1'b1;
               status_in       = ST_ADDED;
            end else begin
               status_in = ST_REFUSED_FUL;
            end
            state_in = S_FINAL;
         end

         // next key in ascending order found; expire or keep it, or end when none is left
         S_SWEEP: begin
            if (!sc_flags.best_ok) begin
               status_in = (mode_ff == MODE_SWEEP) ? ST_SWEPT : ST_CLEARED;
               state_in  = S_FINAL;
            end else begin
               prev_in     = best_key;
               has_prev_in = 1'b1;
               if ((mode_ff == MODE_CLEAR) || (above_min && aged)) begin
                  st_ctrl.clr_vld = 1'b1;
                  sc_ctrl.freed   = 1'b1;
                  count_in        = count_ff - 1'b1;
                  note_key_in     = best_key;
                  ret_in          = S_NEXT;
                  state_in        = S_NOTE;
               end else begin
                  state_in = S_NEXT;
               end
            end
         end

         S_NEXT: begin
            cnt_in        = '0;
            sc_ctrl.start = 1'b1;
            sc_ctrl.kind  = SCAN_NEXT;
            post_in       = S_SWEEP;
            state_in      = S_SCAN;
         end

         S_NOTE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_kind_in   = KIND_NOTE;
               rsp_key_in    = CELL_KEY_W'(note_key_ff);
               rsp_status_in = '0;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_last_in   = 1'b0;
               state_in      = ret_ff;
            end
         end

         S_FINAL: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_kind_in   = KIND_STATUS;
               rsp_key_in    = '0;
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         has_prev_ff  <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         has_prev_ff  <= has_prev_in;
         cnt_ff       <= cnt_in;
      end
   end

   // request and result payload registers
   always_ff @(posedge clock) begin
      post_ff       <= post_in;
      ret_ff        <= ret_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      now_ff        <= now_in;
      status_ff     <= status_in;
      note_key_ff   <= note_key_in;
      prev_ff       <= prev_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = rsp_kind_ff;
   assign rsp.removed_key = rsp_key_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.entry_count = rsp_count_ff;
   assign rsp.last        = rsp_last_ff;

endmodule
